[hw/rtl/tdt_pkg.sv]
package tdt_pkg;

   localparam int BREAKPOINT_COUNT = 32;

   localparam logic [1:0] STATUS_INTERP   = 2'd0;
   localparam logic [1:0] STATUS_CLAMP_HI = 2'd1;
   localparam logic [1:0] STATUS_CLAMP_LO = 2'd2;
   localparam logic [1:0] STATUS_WRITE    = 2'd3;

   localparam logic [0:0] CSR_SUPPLY = 1'd0;
   localparam logic [0:0] CSR_SERIES = 1'd1;

   typedef struct packed {
      logic        mode;
      logic        table_select;
      logic [15:0] sample_millivolts;
      logic [4:0]  entry_index;
      logic [31:0] entry_ohms;
      logic [15:0] entry_centidegrees;
   } item_type;

   typedef struct packed {
      logic [15:0] temperature_centidegrees;
      logic [31:0] resistance_ohms;
      logic [1:0]  range_status;
   } result_type;

endpackage

[hw/rtl/thermistor_divider_temperature.sv]
// Converts divider millivolt samples to hundredths of a degree through one of two
// stored breakpoint tables; one beat in, one beat out. An interpolated conversion
// runs a 40-step restoring division for the resistance, two end-point reads, up to
// five probes of the breakpoint RAM and a 48-step restoring division for the
// interpolation. Clamped conversions end after the end-point checks, samples at or
// above the supply take one table read and table writes go straight to the output.
// Beats pass a two-entry input queue and a one-beat output register, so a stalled
// result holds the engine only once its next result is ready.
module thermistor_divider_temperature (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode, table_select, sample_millivolts, entry_index, entry_ohms, entry_centidegrees
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // temperature_centidegrees, resistance_ohms, range_status
   output logic [55:0] rsp_tdata
);
   import tdt_pkg::*;
   logic [15:0] supply_ff;
   logic [23:0] series_ff;
   item_type qin, qout;
   result_type res;
   logic full, empty, pop;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_SERIES) ? {8'd0, series_ff} : {16'd0, supply_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= 16'd3300;
         series_ff <= 24'd10000;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == {CSR_SUPPLY, 2'b00}) supply_ff <= csr_pwdata[15:0];
         if (csr_paddr == {CSR_SERIES, 2'b00}) series_ff <= csr_pwdata[23:0];
      end
   end
   assign qin = '{req_tdata[0], req_tdata[1], req_tdata[17:2], req_tdata[22:18],
                  req_tdata[54:23], req_tdata[70:55]};
   assign req_tready = !full;
   tdt_fifo u_fifo (.clock(clock), .reset(reset), .push(req_tvalid && !full),
      .push_data(qin), .full(full), .pop(pop), .pop_data(qout), .empty(empty));
   tdt_engine u_engine (.clock(clock),
      .reset(reset), .supply_millivolts(supply_ff), .series_ohms(series_ff),
      .item_valid(!empty), .item(qout), .item_pop(pop), .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready), .rsp(res));
   assign rsp_tdata = {6'd0, res.range_status, res.resistance_ohms,
                       res.temperature_centidegrees};

   a_pop: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("result changed");
endmodule

[hw/rtl/tdt_ram.sv]
module tdt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/tdt_fifo.sv]
module tdt_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tdt_pkg::item_type   push_data,
   output logic                full,
   input  logic                pop,
   output tdt_pkg::item_type   pop_data,
   output logic                empty
);
   import tdt_pkg::*;
   item_type   slot_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign full = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign pop_data = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_data;
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

[hw/rtl/tdt_engine.sv]
module tdt_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         supply_millivolts,
   input  logic [23:0]         series_ohms,
   input  logic                item_valid,
   input  tdt_pkg::item_type   item,
   output logic                item_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tdt_pkg::result_type rsp
);
   import tdt_pkg::*;

   localparam int IW = $clog2(BREAKPOINT_COUNT);
   localparam int AW = IW + 1;
   localparam logic [IW-1:0] LAST = IW'(BREAKPOINT_COUNT - 1);

   localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_RD0 = 4'd2, S_CHK0 = 4'd3,
      S_CHKL = 4'd4, S_PROBE = 4'd5, S_CMP = 4'd6, S_RDL = 4'd7, S_RDR = 4'd8,
      S_MUL = 4'd9, S_DIV2 = 4'd10, S_OUT = 4'd11, S_RDT = 4'd12, S_TOUT = 4'd13,
      S_ABS = 4'd14, S_FIN = 4'd15;

   logic [3:0]  state_ff, state_in;
   logic        sel_ff;
   logic [39:0] dvd_ff;
   logic [15:0] dvs_ff;
   logic [16:0] rem_ff;
   logic [5:0]  cnt_ff;
   logic [31:0] r_ff;
   logic [IW-1:0] left_ff, right_ff, mid_ff, tidx_ff;
   logic [1:0]  status_ff;
   logic [31:0] r0_ff;
   logic signed [16:0] t0_ff;
   logic signed [49:0] num_ff;
   logic [47:0] quo_ff;
   logic        neg_ff;
   logic [32:0] den_ff;
   logic [48:0] qrem_ff;
   logic        resp_ff;
   result_type  res_ff;
   result_type  rsp_ff;

   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_r;
   logic [15:0]   rd_t;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          out_go;

   assign wr_en = item_pop && item.mode && ({3'd0, item.entry_index} < 8'(BREAKPOINT_COUNT));
   assign wr_addr = {item.table_select, item.entry_index[IW-1:0]};

   tdt_ram #(.WIDTH(32), .DEPTH(2*BREAKPOINT_COUNT)) u_ram_r (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(item.entry_ohms),
      .rd_addr(rd_addr), .rd_data(rd_r));
   tdt_ram #(.WIDTH(16), .DEPTH(2*BREAKPOINT_COUNT)) u_ram_t (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(item.entry_centidegrees),
      .rd_addr(rd_addr), .rd_data(rd_t));

   logic narrow;
   assign narrow = ({1'b0, left_ff} + {{IW{1'b0}}, 1'b1}) < {1'b0, right_ff};

   logic [IW-1:0] rd_idx;
   always_comb begin
      unique case (state_ff)
         S_DIV, S_RD0:  rd_idx = '0;
         S_CHK0:        rd_idx = LAST;
         S_PROBE:       rd_idx = narrow ? mid_ff : left_ff;
         S_RDL:         rd_idx = right_ff;
         default:       rd_idx = tidx_ff;
      endcase
   end
   assign rd_addr = {sel_ff, rd_idx};

   assign out_go = (state_ff == S_OUT) && (!resp_ff || rsp_ready);
   assign item_pop = (state_ff == S_IDLE) && item_valid;
   assign rsp_valid = resp_ff;
   assign rsp = rsp_ff;

   logic [16:0] rem_sh, rem_sub;
   assign rem_sh = {rem_ff[15:0], dvd_ff[39]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   logic [48:0] qsh;
   logic [48:0] qsub;
   assign qsh = {qrem_ff[47:0], quo_ff[47]};
   assign qsub = qsh - {16'd0, den_ff};

   logic signed [16:0] tdiff;
   logic signed [49:0] span_prod, base_prod;
   assign tdiff = $signed({rd_t[15], rd_t}) - t0_ff;
   assign span_prod = $signed({1'b0, r0_ff - r_ff}) * tdiff;
   assign base_prod = t0_ff * $signed(den_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (item_pop) state_in = item.mode ? S_OUT :
                     (item.sample_millivolts >= supply_millivolts) ? S_RDT : S_DIV;
         S_DIV:   if (cnt_ff == 6'd39) state_in = S_RD0;
         S_RD0:   state_in = S_CHK0;
         S_CHK0:  state_in = S_CHKL;
         S_CHKL:  state_in = (status_ff != STATUS_INTERP) ? S_TOUT :
                     (r_ff <= rd_r) ? S_RDT : S_PROBE;
         S_PROBE: state_in = narrow ? S_CMP : S_RDL;
         S_CMP:   state_in = (rd_r == r_ff) ? S_RDT : S_PROBE;
         S_RDL:   state_in = S_RDR;
         S_RDR:   state_in = S_MUL;
         S_MUL:   state_in = S_ABS;
         S_ABS:   state_in = S_DIV2;
         S_DIV2:  if (cnt_ff == 6'd47) state_in = S_FIN;
         S_FIN:   state_in = S_OUT;
         S_RDT:   state_in = S_TOUT;
         S_TOUT:  state_in = S_OUT;
         S_OUT:   if (out_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: if (item_pop) begin
            sel_ff <= item.table_select;
            dvd_ff <= {16'd0, series_ohms} * {24'd0, item.sample_millivolts};
            dvs_ff <= supply_millivolts - item.sample_millivolts;
            rem_ff <= '0;
            cnt_ff <= '0;
            if (item.mode) begin
               res_ff <= '{16'd0, 32'd0, STATUS_WRITE};
            end else if (item.sample_millivolts > supply_millivolts) begin
               tidx_ff <= LAST; r_ff <= '0; status_ff <= STATUS_CLAMP_LO;
            end else if (item.sample_millivolts == supply_millivolts) begin
               tidx_ff <= '0; r_ff <= '1; status_ff <= STATUS_CLAMP_HI;
            end
         end
         S_DIV: begin
            cnt_ff <= cnt_ff + 6'd1;
            if (!rem_sub[16]) rem_ff <= rem_sub; else rem_ff <= rem_sh;
            dvd_ff <= {dvd_ff[38:0], !rem_sub[16]};
            status_ff <= STATUS_INTERP;
         end
         S_RD0: r_ff <= (|dvd_ff[39:32]) ? 32'hFFFF_FFFF : dvd_ff[31:0];
         S_CHK0: if (r_ff >= rd_r) begin
            status_ff <= STATUS_CLAMP_HI; tidx_ff <= '0;
         end
         S_CHKL: begin
            if (status_ff == STATUS_INTERP && r_ff <= rd_r) begin
               status_ff <= STATUS_CLAMP_LO; tidx_ff <= LAST;
            end
            left_ff <= '0; right_ff <= LAST;
            mid_ff <= IW'(LAST >> 1);
         end
         S_PROBE: ;
         S_CMP: begin
            if (rd_r == r_ff) begin
               tidx_ff <= mid_ff;
            end else if (rd_r > r_ff) begin
               left_ff <= mid_ff;
               mid_ff <= IW'(({1'b0, mid_ff} + {1'b0, right_ff}) >> 1);
            end else begin
               right_ff <= mid_ff;
               mid_ff <= IW'(({1'b0, left_ff} + {1'b0, mid_ff}) >> 1);
            end
         end
         S_RDL: begin r0_ff <= rd_r; t0_ff <= $signed({rd_t[15], rd_t}); end
         S_RDR: begin
            den_ff <= {1'b0, r0_ff} - {1'b0, rd_r};
            num_ff <= span_prod;
         end
         S_MUL: num_ff <= num_ff + base_prod;
         S_ABS: begin
            neg_ff <= num_ff[49];
            quo_ff <= 48'(num_ff[49] ? -num_ff : num_ff);
            qrem_ff <= '0;
            cnt_ff <= '0;
         end
         S_DIV2: begin
            cnt_ff <= cnt_ff + 6'd1;
            if (!qsub[48]) qrem_ff <= qsub; else qrem_ff <= qsh;
            quo_ff <= {quo_ff[46:0], !qsub[48]};
         end
         S_FIN: res_ff <= '{neg_ff ? 16'd0 - quo_ff[15:0] : quo_ff[15:0], r_ff,
                            STATUS_INTERP};
         S_RDT: ;
         S_TOUT: res_ff <= '{rd_t, r_ff, status_ff};
         S_OUT: if (out_go) rsp_ff <= res_ff;
         default: ;
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
         resp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_go) resp_ff <= 1'b1;
         else if (rsp_ready) resp_ff <= 1'b0;
      end
   end
endmodule
